>>> sv/cdgl_pkg.sv
// Package with the widths, microcode formats and microprogram of the divisor core.
package cdgl_pkg;

  // Field widths and operand width.
  localparam int OPW         = 12;
  localparam int IN_W        = 12;
  localparam int DIVW        = 12;
  localparam int LCMW        = 24;
  localparam int MAX_RESULTS = 41;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int STEP_CNT_W  = $clog2(OPW + 1);
  localparam int PC_W        = 4;

  typedef logic [PC_W-1:0] pc_t;

  // Datapath operations selected by a control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_A,
    OP_DIV_B,
    OP_DIV_BEST,
    OP_DIV_STEP,
    OP_HIT,
    OP_INC,
    OP_MUL,
    OP_EMIT_LAST
  } op_t;

  // Jump conditions; when the condition holds, the sequencer goes to the target.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_OVER_LIMIT,
    C_DIV_BUSY,
    C_REM_NZ,
    C_OUT_FULL,
    C_BEST_ZERO
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  // Step addresses of the microprogram.
  localparam pc_t S_IDLE      = 4'd0;
  localparam pc_t S_CHECK     = 4'd1;
  localparam pc_t S_DIVA      = 4'd2;
  localparam pc_t S_DIVA_RUN  = 4'd3;
  localparam pc_t S_TEST_A    = 4'd4;
  localparam pc_t S_DIVB      = 4'd5;
  localparam pc_t S_DIVB_RUN  = 4'd6;
  localparam pc_t S_TEST_B    = 4'd7;
  localparam pc_t S_HIT       = 4'd8;
  localparam pc_t S_INC       = 4'd9;
  localparam pc_t S_FIN_DIV   = 4'd10;
  localparam pc_t S_FIN_RUN   = 4'd11;
  localparam pc_t S_MUL       = 4'd12;
  localparam pc_t S_EMIT_LAST = 4'd13;

  // Microprogram: trial division over every candidate, then gcd and lcm.
  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t cw;
    unique case (pc)
      S_IDLE:      cw = '{OP_LOAD,      C_NO_INPUT,   S_IDLE};
      S_CHECK:     cw = '{OP_NOP,       C_OVER_LIMIT, S_FIN_DIV};
      S_DIVA:      cw = '{OP_DIV_A,     C_NEVER,      S_IDLE};
      S_DIVA_RUN:  cw = '{OP_DIV_STEP,  C_DIV_BUSY,   S_DIVA_RUN};
      S_TEST_A:    cw = '{OP_NOP,       C_REM_NZ,     S_INC};
      S_DIVB:      cw = '{OP_DIV_B,     C_NEVER,      S_IDLE};
      S_DIVB_RUN:  cw = '{OP_DIV_STEP,  C_DIV_BUSY,   S_DIVB_RUN};
      S_TEST_B:    cw = '{OP_NOP,       C_REM_NZ,     S_INC};
      S_HIT:       cw = '{OP_HIT,       C_OUT_FULL,   S_HIT};
      S_INC:       cw = '{OP_INC,       C_ALWAYS,     S_CHECK};
      S_FIN_DIV:   cw = '{OP_DIV_BEST,  C_BEST_ZERO,  S_EMIT_LAST};
      S_FIN_RUN:   cw = '{OP_DIV_STEP,  C_DIV_BUSY,   S_FIN_RUN};
      S_MUL:       cw = '{OP_MUL,       C_NEVER,      S_IDLE};
      S_EMIT_LAST: cw = '{OP_EMIT_LAST, C_OUT_FULL,   S_EMIT_LAST};
      default:     cw = '{OP_NOP,       C_ALWAYS,     S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

>>> sv/common_divisors_gcd_lcm_core.sv
// Steps: for each candidate divisor a shift-subtract divider run finds the remainder of
// the first operand; when that is zero, a second run tests the second operand; the
// gcd/lcm tail adds one more division and a multiply, skipped with a zero operand.
// A new operand pair is taken only in the idle step, after the previous pair's last word.
// Reset returns the sequencer to its idle step with no result word pending.
module common_divisors_gcd_lcm_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cdgl_pkg::IN_W-1:0]    first_operand,
  input  logic [cdgl_pkg::IN_W-1:0]    second_operand,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cdgl_pkg::DIVW-1:0]    common_divisor,
  output logic [cdgl_pkg::DIVW-1:0]    greatest_divisor,
  output logic [cdgl_pkg::LCMW-1:0]    least_multiple,
  output logic                         last
);
  import cdgl_pkg::*;

  pc_t                   pc;
  pc_t                   pc_next;
  ctrl_word_t            cw;
  logic                  jump;

  logic [OPW-1:0]        held_first;
  logic [OPW-1:0]        held_second;
  logic [OPW-1:0]        limit;
  logic [OPW:0]          trial_divisor;
  logic [OPW-1:0]        best_divisor;
  logic [CNT_W-1:0]      count;

  logic [OPW-1:0]        dq;
  logic [OPW-1:0]        rem;
  logic [OPW-1:0]        dv;
  logic [STEP_CNT_W-1:0] div_cnt;
  logic [OPW:0]          shifted;
  logic [OPW:0]          diff;
  logic                  fits;

  logic [OPW-1:0]        op_a;
  logic [OPW-1:0]        op_b;
  logic [2*OPW-1:0]      product;
  logic [LCMW-1:0]       lcm;
  logic                  out_free;

  assign cw       = ucode(pc);
  assign in_stall = (pc != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign op_a     = OPW'(first_operand);
  assign op_b     = OPW'(second_operand);

  // Divider step: shift in the next dividend bit and subtract when it fits.
  assign shifted = {rem, dq[OPW-1]};
  assign diff    = shifted - {1'b0, dv};
  assign fits    = (shifted >= {1'b0, dv});
  assign product = dq * held_second;

  // Jump condition decode.
  always_comb begin
    unique case (cw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_INPUT:   jump = !in_valid;
      C_OVER_LIMIT: jump = (trial_divisor > {1'b0, limit});
      C_DIV_BUSY:   jump = (div_cnt != '0);
      C_REM_NZ:     jump = (rem != '0);
      C_OUT_FULL:   jump = !out_free;
      C_BEST_ZERO:  jump = (best_divisor == '0);
      default:      jump = 1'b0;
    endcase
  end

  // Step counter: go to the target on a taken jump, else fall through.
  always_comb begin
    pc_next = jump ? cw.target : pc_t'(pc + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Datapath driven by the current control word.
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (in_valid) begin
          held_first    <= op_a;
          held_second   <= op_b;
          limit         <= (op_a < op_b) ? op_a : op_b;
          trial_divisor <= (OPW+1)'(1);
          best_divisor  <= '0;
          count         <= '0;
        end
      end
      OP_DIV_A: begin
        dq      <= held_first;
        dv      <= trial_divisor[OPW-1:0];
        rem     <= '0;
        div_cnt <= STEP_CNT_W'(OPW);
      end
      OP_DIV_B: begin
        dq      <= held_second;
        dv      <= trial_divisor[OPW-1:0];
        rem     <= '0;
        div_cnt <= STEP_CNT_W'(OPW);
      end
      OP_DIV_BEST: begin
        dq      <= held_first;
        dv      <= best_divisor;
        rem     <= '0;
        div_cnt <= STEP_CNT_W'(OPW);
        lcm     <= '0;
      end
      OP_DIV_STEP: begin
        if (div_cnt != '0) begin
          rem     <= fits ? diff[OPW-1:0] : shifted[OPW-1:0];
          dq      <= {dq[OPW-2:0], fits};
          div_cnt <= div_cnt - 1'b1;
        end
      end
      OP_HIT: begin
        if (out_free) begin
          best_divisor <= trial_divisor[OPW-1:0];
          if (count < CNT_W'(MAX_RESULTS - 1)) begin
            count <= count + 1'b1;
          end
        end
      end
      OP_INC: begin
        trial_divisor <= trial_divisor + 1'b1;
      end
      OP_MUL: begin
        lcm <= LCMW'(product);
      end
      default: begin
      end
    endcase
  end

  // Output word register; a new word is written only when it is empty or the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_HIT && out_free && count < CNT_W'(MAX_RESULTS - 1)) begin
      out_valid <= 1'b1;
    end else if (cw.op == OP_EMIT_LAST && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_HIT && out_free && count < CNT_W'(MAX_RESULTS - 1)) begin
      common_divisor   <= DIVW'(trial_divisor);
      greatest_divisor <= '0;
      least_multiple   <= '0;
      last             <= 1'b0;
    end else if (cw.op == OP_EMIT_LAST && out_free) begin
      common_divisor   <= '0;
      greatest_divisor <= DIVW'(best_divisor);
      least_multiple   <= lcm;
      last             <= 1'b1;
    end
  end

endmodule
